@@ sv/salc_pkg.sv @@
// Shared constants for the set-associative LRU tag cache.
// No dependencies; imported by set_assoc_lru_tag_cache and tb_top.
package salc_pkg;

	localparam int KEY_W     = 32;
	localparam int KEY_BIT_W = $clog2(KEY_W);
	localparam int SET_OUT_W = 6;
	localparam int WAY_OUT_W = 2;
	localparam int TOTAL_W   = 32;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [TOTAL_W-1:0] total_t;

endpackage

@@ sv/set_assoc_lru_tag_cache.sv @@
// Set-associative tag cache with LRU replacement, dirty tracking and running counters.
// Depends on salc_pkg for field widths; holds the tag and metadata memories itself.
//
// One key lookup is a transaction: it is taken when start is high and busy is low, and
// its result shows on the result ports for exactly one cycle while done is high; the
// receiver cannot hold it off. When NUM_SETS is a power of two a lookup reads the set row
// from the tag and metadata memories, then compares all ways, updates LRU order, writes
// the row back and registers the result; otherwise a divide state and a modulo state
// before the read form key mod NUM_SETS by a reciprocal multiplication and a single
// compare and subtract. One lookup is in flight at a time, so a row is never read while
// being written. After reset busy stays high while every set of the metadata memory is
// swept to all-invalid, all-clean and identity LRU order.
module set_assoc_lru_tag_cache
	import salc_pkg::*;
#(
	parameter int NUM_SETS = 64,
	parameter int WAYS     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [KEY_W-1:0]     key,
	input  logic                 mark_modified,
	output logic                 done,
	output logic                 hit,
	output logic [SET_OUT_W-1:0] set_index,
	output logic [WAY_OUT_W-1:0] way,
	output logic                 evicted,
	output logic [KEY_W-1:0]     evicted_key,
	output logic                 write_back,
	output logic [TOTAL_W-1:0]   hit_total,
	output logic [TOTAL_W-1:0]   miss_total,
	output logic [TOTAL_W-1:0]   writeback_total
);

	localparam int  SETW     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int  WW       = $clog2(WAYS);
	localparam bit  SETS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
	localparam logic [KEY_W-1:0]   NSETS_KEY = KEY_W'(NUM_SETS);
	// floor(2^32 / NUM_SETS), only needed when NUM_SETS is not a power of two
	localparam logic [KEY_W-1:0]   RECIP     =
		SETS_POW2 ? '0 : KEY_W'(64'h1_0000_0000 / 64'(NUM_SETS));
	localparam logic [KEY_W-1:0]   SET_MASK  = KEY_W'(NUM_SETS - 1);
	localparam logic [SETW-1:0]    LAST_SET  = SETW'(NUM_SETS - 1);

	typedef struct packed {
		logic [WAYS-1:0]         valid;
		logic [WAYS-1:0]         dirty;
		logic [WAYS-1:0][WW-1:0] lru;   // most recent first
	} meta_t;

	typedef logic [WAYS-1:0][KEY_W-1:0] tag_row_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_MOD,
		ST_RD,
		ST_UPD
	} state_t;

	function automatic meta_t ident_meta();
		meta_t m;
		m.valid = '0;
		m.dirty = '0;
		for (int i = 0; i < WAYS; i++) begin
			m.lru[i] = WW'(i);
		end
		return m;
	endfunction

	// memories
	tag_row_t tag_mem  [NUM_SETS];
	meta_t    meta_mem [NUM_SETS];

	state_t               state_q;
	logic [SETW-1:0]      clr_q;
	logic [KEY_W-1:0]     key_q;
	logic                 mark_q;
	logic [SETW-1:0]      set_q;
	logic [KEY_W-1:0]     quo_q;
	tag_row_t             tag_rd_q;
	meta_t                meta_rd_q;
	total_t               hit_cnt_q;
	total_t               miss_cnt_q;
	total_t               wb_cnt_q;

	// lookup results
	logic           hit_c;
	logic           free_c;
	logic [WW-1:0]  hit_way_c;
	logic [WW-1:0]  free_way_c;
	logic [WW-1:0]  target_c;
	logic           evict_c;
	logic           wb_c;
	logic [KEY_W-1:0] ev_key_c;
	logic [WW-1:0]  pos_c;
	logic           pos_found_c;
	meta_t          new_meta_c;
	tag_row_t       new_tags_c;
	logic [2*KEY_W-1:0] prod_c;
	logic [KEY_W-1:0]   rem_c;
	logic [SETW-1:0]    mod_c;

	// key mod NUM_SETS: the quotient estimate is at most one low, so one
	// compare and subtract finishes the remainder
	always_comb begin
		prod_c = {{KEY_W{1'b0}}, key_q} * {{KEY_W{1'b0}}, RECIP};
		rem_c  = key_q - quo_q * NSETS_KEY;
		if (rem_c >= NSETS_KEY) begin
			rem_c = rem_c - NSETS_KEY;
		end
		mod_c = rem_c[SETW-1:0];
	end

	always_comb begin
		hit_c       = 1'b0;
		hit_way_c   = '0;
		free_c      = 1'b0;
		free_way_c  = '0;
		pos_c       = WW'(WAYS - 1);
		pos_found_c = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit_c && meta_rd_q.valid[w] && tag_rd_q[w] == key_q) begin
				hit_c     = 1'b1;
				hit_way_c = WW'(w);
			end
			if (!free_c && !meta_rd_q.valid[w]) begin
				free_c     = 1'b1;
				free_way_c = WW'(w);
			end
		end
		if (hit_c) begin
			target_c = hit_way_c;
		end else if (free_c) begin
			target_c = free_way_c;
		end else begin
			target_c = meta_rd_q.lru[WAYS-1];
		end
		evict_c  = !hit_c && !free_c;
		ev_key_c = evict_c ? tag_rd_q[target_c] : '0;
		wb_c     = evict_c && meta_rd_q.dirty[target_c];

		// move target to the front of the recency list
		for (int i = 0; i < WAYS; i++) begin
			if (!pos_found_c && meta_rd_q.lru[i] == target_c) begin
				pos_c       = WW'(i);
				pos_found_c = 1'b1;
			end
		end
		new_meta_c = meta_rd_q;
		new_meta_c.lru[0] = target_c;
		for (int i = 1; i < WAYS; i++) begin
			if (WW'(i) <= pos_c) begin
				new_meta_c.lru[i] = meta_rd_q.lru[i-1];
			end
		end
		new_meta_c.valid[target_c] = 1'b1;
		new_meta_c.dirty[target_c] = hit_c ? (meta_rd_q.dirty[target_c] | mark_q) : mark_q;

		new_tags_c = tag_rd_q;
		new_tags_c[target_c] = key_q;
	end

	// memory ports: one read, one write per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			meta_mem[clr_q] <= ident_meta();
		end else if (state_q == ST_UPD) begin
			meta_mem[set_q] <= new_meta_c;
			tag_mem[set_q]  <= new_tags_c;
		end
		if (state_q == ST_RD) begin
			meta_rd_q <= meta_mem[set_q];
			tag_rd_q  <= tag_mem[set_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			quo_q       <= '0;
			set_q       <= '0;
			key_q       <= '0;
			mark_q      <= 1'b0;
			done        <= 1'b0;
			hit         <= 1'b0;
			set_index   <= '0;
			way         <= '0;
			evicted     <= 1'b0;
			evicted_key <= '0;
			write_back  <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			wb_cnt_q    <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SET) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						key_q  <= key;
						mark_q <= mark_modified;
						if (SETS_POW2) begin
							set_q   <= SETW'(key & SET_MASK);
							state_q <= ST_RD;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					quo_q   <= prod_c[2*KEY_W-1:KEY_W];
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					set_q   <= mod_c;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					done        <= 1'b1;
					hit         <= hit_c;
					set_index   <= SET_OUT_W'(set_q);
					way         <= WAY_OUT_W'(target_c);
					evicted     <= evict_c;
					evicted_key <= ev_key_c;
					write_back  <= wb_c;
					if (hit_c) begin
						hit_cnt_q <= hit_cnt_q + 1'b1;
					end else begin
						miss_cnt_q <= miss_cnt_q + 1'b1;
					end
					if (wb_c) begin
						wb_cnt_q <= wb_cnt_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign hit_total       = hit_cnt_q;
	assign miss_total      = miss_cnt_q;
	assign writeback_total = wb_cnt_q;

	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPD))
		else $error("result strobe without an update cycle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not make the block busy");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> !evicted)
		else $error("hit reported an eviction");

	a_wb_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && write_back) |-> evicted)
		else $error("write-back without eviction");

	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !evicted) |-> (evicted_key == '0))
		else $error("evicted key nonzero without eviction");

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for set_assoc_lru_tag_cache: a negedge driver feeds key lookups from a
// queue, and a posedge monitor predicts each lookup and compares the strobed result.
// Depends on salc_pkg and set_assoc_lru_tag_cache.
module tb_top;
	import salc_pkg::*;

	localparam int NUM_SETS       = 64;
	localparam int WAYS           = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int RANDOM_ITEMS   = 950;

	typedef struct {
		key_t        key;
		logic        mark;
		int unsigned idle_pct;
	} lookup_req_t;

	typedef struct {
		logic                 hit;
		logic [SET_OUT_W-1:0] set_index;
		logic [WAY_OUT_W-1:0] way;
		logic                 evicted;
		key_t                 evicted_key;
		logic                 write_back;
		total_t               hits;
		total_t               misses;
		total_t               writebacks;
	} lookup_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	key_t                 key = '0;
	logic                 mark_modified = 1'b0;
	logic                 done;
	logic                 hit;
	logic [SET_OUT_W-1:0] set_index;
	logic [WAY_OUT_W-1:0] way;
	logic                 evicted;
	key_t                 evicted_key;
	logic                 write_back;
	total_t               hit_total;
	total_t               miss_total;
	total_t               writeback_total;

	lookup_req_t    pending_lookups[$];
	lookup_result_t expected_lookups[$];

	// shadow cache state
	key_t   tag_mem[NUM_SETS][WAYS];
	bit     line_valid[NUM_SETS][WAYS];
	bit     line_dirty[NUM_SETS][WAYS];
	int     lru_list[NUM_SETS][WAYS];
	total_t hit_count;
	total_t miss_count;
	total_t writeback_count;

	bit took = 1'b0;
	int idle_cycles = 0;
	int mismatches = 0;

	set_assoc_lru_tag_cache #(
		.NUM_SETS(NUM_SETS),
		.WAYS(WAYS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.key(key),
		.mark_modified(mark_modified),
		.done(done),
		.hit(hit),
		.set_index(set_index),
		.way(way),
		.evicted(evicted),
		.evicted_key(evicted_key),
		.write_back(write_back),
		.hit_total(hit_total),
		.miss_total(miss_total),
		.writeback_total(writeback_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic predict_lookup(input key_t k, input logic mk);
		lookup_result_t r;
		int  s;
		int  tgt;
		int  pos;
		bit  found;
		s = int'(k % NUM_SETS);
		tgt = 0;
		found = 1'b0;
		r.evicted = 1'b0;
		r.evicted_key = '0;
		r.write_back = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && line_valid[s][w] && tag_mem[s][w] == k) begin
				found = 1'b1;
				tgt = w;
			end
		end
		r.hit = found;
		if (found) begin
			hit_count++;
		end else begin
			miss_count++;
			for (int w = 0; w < WAYS; w++) begin
				if (!found && !line_valid[s][w]) begin
					found = 1'b1;
					tgt = w;
				end
			end
			// full set: displace the least recent way
			if (!found) begin
				tgt = lru_list[s][WAYS-1];
				r.evicted = 1'b1;
				r.evicted_key = tag_mem[s][tgt];
				if (line_dirty[s][tgt]) begin
					r.write_back = 1'b1;
					writeback_count++;
				end
			end
			tag_mem[s][tgt] = k;
			line_valid[s][tgt] = 1'b1;
			line_dirty[s][tgt] = 1'b0;
		end
		pos = WAYS - 1;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (lru_list[s][i] == tgt)
				pos = i;
		end
		for (int i = pos; i > 0; i--)
			lru_list[s][i] = lru_list[s][i-1];
		lru_list[s][0] = tgt;
		if (mk)
			line_dirty[s][tgt] = 1'b1;
		r.set_index = s[SET_OUT_W-1:0];
		r.way = tgt[WAY_OUT_W-1:0];
		r.hits = hit_count;
		r.misses = miss_count;
		r.writebacks = writeback_count;
		expected_lookups.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_lookup(input key_t k, input logic mk, input int unsigned pct);
		lookup_req_t req;
		req.key = k;
		req.mark = mk;
		req.idle_pct = pct;
		pending_lookups.push_back(req);
	endtask

	// driver: present the next lookup once the previous transaction is taken
	always @(negedge clk) begin : drive
		lookup_req_t req;
		if (arst_n && (took || !start)) begin
			if (pending_lookups.size() > 0 &&
			    $urandom_range(99) >= pending_lookups[0].idle_pct) begin
				req = pending_lookups.pop_front();
				start <= 1'b1;
				key <= req.key;
				mark_modified <= req.mark;
			end else begin
				start <= 1'b0;
				key <= $urandom;
				mark_modified <= 1'($urandom_range(1));
			end
		end
	end

	// monitor: check strobed results, predict accepted lookups, run the watchdog
	always @(posedge clk) begin : watch
		lookup_result_t exp_r;
		bit progress;
		progress = 1'b0;
		took = 1'b0;
		if (arst_n) begin
			if (done) begin
				progress = 1'b1;
				if (expected_lookups.size() == 0) begin
					$display("%0t: result with no lookup outstanding, actual key set %0h way %0h",
						$time, set_index, way);
					mismatches++;
				end else begin
					exp_r = expected_lookups.pop_front();
					check_field("hit", exp_r.hit, hit);
					check_field("set_index", exp_r.set_index, set_index);
					check_field("way", exp_r.way, way);
					check_field("evicted", exp_r.evicted, evicted);
					check_field("evicted_key", exp_r.evicted_key, evicted_key);
					check_field("write_back", exp_r.write_back, write_back);
					check_field("hit_total", exp_r.hits, hit_total);
					check_field("miss_total", exp_r.misses, miss_total);
					check_field("writeback_total", exp_r.writebacks, writeback_total);
				end
			end
			if (start && !busy) begin
				progress = 1'b1;
				took = 1'b1;
				predict_lookup(key, mark_modified);
			end
		end
		if (progress) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d lookups outstanding", $time,
					expected_lookups.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned phase_pct[4];
		int unsigned pick;
		int unsigned setsel;
		int unsigned upper;
		key_t k;

		phase_pct = '{0, 83, 0, 12};
		for (int s = 0; s < NUM_SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				tag_mem[s][w] = '0;
				line_valid[s][w] = 1'b0;
				line_dirty[s][w] = 1'b0;
				lru_list[s][w] = w;
			end
		end
		hit_count = '0;
		miss_count = '0;
		writeback_count = '0;

		// fill set 0, hit, then evict clean and dirty lines and refill
		queue_lookup(32'd0, 1'b1, 0);
		queue_lookup(32'd64, 1'b0, 0);
		queue_lookup(32'd128, 1'b1, 0);
		queue_lookup(32'd192, 1'b0, 0);
		queue_lookup(32'd0, 1'b0, 0);
		queue_lookup(32'd256, 1'b0, 0);
		queue_lookup(32'd320, 1'b0, 0);
		queue_lookup(32'd128, 1'b0, 0);
		queue_lookup(32'd256, 1'b1, 0);
		queue_lookup(32'd0, 1'b0, 0);
		queue_lookup(32'd384, 1'b0, 0);
		queue_lookup(32'd320, 1'b0, 0);
		// extreme keys in the top set, set 0 and two other sets
		queue_lookup(32'hFFFF_FFFF, 1'b1, 0);
		queue_lookup(32'hFFFF_FFBF, 1'b0, 0);
		queue_lookup(32'h7FFF_FFFF, 1'b0, 0);
		queue_lookup(32'hBFFF_FFFF, 1'b1, 0);
		queue_lookup(32'h0000_003F, 1'b0, 0);
		queue_lookup(32'hFFFF_FFFF, 1'b0, 0);
		queue_lookup(32'hFFFF_FFC0, 1'b1, 0);
		queue_lookup(32'h8000_0000, 1'b0, 0);
		queue_lookup(32'hAAAA_AAAA, 1'b1, 0);
		queue_lookup(32'h5555_5555, 1'b0, 0);

		// mostly small tag pools, half of them on sets 0 to 3, so hits, fills and evictions all happen
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				k = $urandom;
			end else begin
				setsel = (pick < 60) ? $urandom_range(3) : $urandom_range(NUM_SETS - 1);
				upper = ($urandom_range(9) == 0) ? 32'h03FF_FFFF : $urandom_range(5);
				k = (key_t'(upper) << 6) | key_t'(setsel);
			end
			queue_lookup(k, $urandom_range(2) == 0, phase_pct[(n * 4) / RANDOM_ITEMS]);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_lookups.size() != 0 || expected_lookups.size() != 0 || start)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ set_assoc_lru_tag_cache.f @@
sv/salc_pkg.sv
sv/set_assoc_lru_tag_cache.sv
sim/tb_top.sv
